// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

// ===== hw/rtl/cdir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdir_pkg
// Types, constants and helpers of the coherence directory.
// ----------------------------------------------------------------------------
package cdir_pkg;

    localparam int NUM_CACHES      = 8;
    localparam int LINE_INDEX_BITS = 10;
    localparam int SHARER_W        = 8;
    localparam int CACHE_ID_W      = 3;
    localparam int STATE_W         = 2;

    localparam logic [SHARER_W-1:0] HOLDER_MASK =
        (NUM_CACHES >= SHARER_W) ? {SHARER_W{1'b1}} : SHARER_W'((1 << NUM_CACHES) - 1);

    localparam logic [STATE_W-1:0] MODE_I = 2'd0;
    localparam logic [STATE_W-1:0] MODE_S = 2'd1;
    localparam logic [STATE_W-1:0] MODE_E = 2'd2;
    localparam logic [STATE_W-1:0] MODE_M = 2'd3;

    localparam logic KIND_DOWNGRADE = 1'b0;
    localparam logic KIND_GRANT     = 1'b1;

    typedef struct packed {
        logic [STATE_W-1:0]         mode;
        logic [CACHE_ID_W-1:0]      requester;
        logic [LINE_INDEX_BITS-1:0] line_index;
    } t_req;

    typedef struct packed {
        logic                       kind;
        logic [CACHE_ID_W-1:0]      target;
        logic [STATE_W-1:0]         new_state;
        logic                       safe;
        logic [LINE_INDEX_BITS-1:0] line_out;
        logic                       last;
    } t_rsp;

    typedef struct packed {
        logic [SHARER_W-1:0]   sharers;
        logic                  owner_valid;
        logic [CACHE_ID_W-1:0] owner_id;
        logic                  shared_flag;
        logic                  read_only;
        logic                  modified_flag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam t_entry ENTRY_RESET = '{
        sharers:       '0,
        owner_valid:   1'b0,
        owner_id:      '0,
        shared_flag:   1'b0,
        read_only:     1'b1,
        modified_flag: 1'b0
    };

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clearing;
        logic pending;
    } t_status;

    function automatic logic [CACHE_ID_W-1:0] lowest_id(input logic [SHARER_W-1:0] v);
        logic [CACHE_ID_W-1:0] idx;
        idx = '0;
        for (int i = SHARER_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = CACHE_ID_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic is_onehot(input logic [SHARER_W-1:0] v);
        return (v != '0) && ((v & (v - SHARER_W'(1))) == '0);
    endfunction

endpackage

// ===== hw/rtl/coherence_directory_with_safety.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coherence_directory_with_safety
// Per-line coherence directory with sharer set and safety tracking.
// ----------------------------------------------------------------------------
// After reset the directory memory is swept to its reset value, one line per
// cycle; no request is taken until the sweep ends. For a request, the entry is
// read from the single directory RAM, updated and written back the next cycle,
// then downgrades go out one per cycle while the result side does not stall,
// and the cycle that hands over the grant also takes the next request.
// Results pass through one output register.
`include "assert_macros.svh"

module coherence_directory_with_safety (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  cdir_pkg::t_req  i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output cdir_pkg::t_rsp  o_out,
    input  logic            i_cfg_wr_en,
    input  logic            i_cfg_wr_data
);

    logic                                 r_allow_reverse;
    logic                                 ram_we;
    logic [cdir_pkg::LINE_INDEX_BITS-1:0] ram_waddr;
    logic [cdir_pkg::ENTRY_W-1:0]         ram_wdata;
    logic                                 ram_re;
    logic [cdir_pkg::LINE_INDEX_BITS-1:0] ram_raddr;
    logic [cdir_pkg::ENTRY_W-1:0]         ram_rdata;
    logic                                 res_valid;
    logic                                 res_ready;
    cdir_pkg::t_rsp                       res;
    cdir_pkg::t_status                    status;
    logic                                 out_dg;
    logic                                 dg_state_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_reverse <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_allow_reverse <= i_cfg_wr_data;
        end
    end

    cdir_ram #(
        .ADDR_W (cdir_pkg::LINE_INDEX_BITS),
        .DATA_W (cdir_pkg::ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cdir_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in            (i_in),
        .o_in_stall      (o_in_stall),
        .i_allow_reverse (r_allow_reverse),
        .o_ram_we        (ram_we),
        .o_ram_waddr     (ram_waddr),
        .o_ram_wdata     (ram_wdata),
        .o_ram_re        (ram_re),
        .o_ram_raddr     (ram_raddr),
        .i_ram_rdata     (ram_rdata),
        .o_res_valid     (res_valid),
        .o_res           (res),
        .i_res_ready     (res_ready),
        .o_status        (status)
    );

    cdir_outreg u_outreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    assign out_dg      = o_out_valid && (o_out.kind == cdir_pkg::KIND_DOWNGRADE);
    assign dg_state_ok = o_out.new_state inside {cdir_pkg::MODE_I, cdir_pkg::MODE_S};

    `ASSERT_IMPLY(a_clear_stall, i_clk, i_rst_n, status.clearing, o_in_stall)
    `ASSERT_IMPLY(a_clear_quiet, i_clk, i_rst_n, status.clearing, !o_out_valid)
    `ASSERT_IMPLY(a_pend_stall, i_clk, i_rst_n, status.pending, o_in_stall)
    `ASSERT_IMPLY(a_last_grant, i_clk, i_rst_n, o_out_valid, o_out.last == o_out.kind)
    `ASSERT_IMPLY(a_dg_state, i_clk, i_rst_n, out_dg, dg_state_ok)

endmodule

// ===== hw/rtl/cdir_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdir_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cdir_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 15
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/cdir_outreg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdir_outreg
// Output register between the directory engine and the result channel.
// ----------------------------------------------------------------------------
module cdir_outreg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_res_valid,
    input  cdir_pkg::t_rsp  i_res,
    output logic            o_res_ready,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output cdir_pkg::t_rsp  o_out
);

    logic           r_valid;
    cdir_pkg::t_rsp r_data;

    assign o_res_ready = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_data <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_data;

endmodule

// ===== hw/rtl/cdir_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdir_ctrl
// Directory engine: clearing sweep, read-modify-write of one entry,
// downgrade sequencing and grant.
// ----------------------------------------------------------------------------
module cdir_ctrl (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  cdir_pkg::t_req                       i_in,
    output logic                                 o_in_stall,
    input  logic                                 i_allow_reverse,
    output logic                                 o_ram_we,
    output logic [cdir_pkg::LINE_INDEX_BITS-1:0] o_ram_waddr,
    output logic [cdir_pkg::ENTRY_W-1:0]         o_ram_wdata,
    output logic                                 o_ram_re,
    output logic [cdir_pkg::LINE_INDEX_BITS-1:0] o_ram_raddr,
    input  logic [cdir_pkg::ENTRY_W-1:0]         i_ram_rdata,
    output logic                                 o_res_valid,
    output cdir_pkg::t_rsp                       o_res,
    input  logic                                 i_res_ready,
    output cdir_pkg::t_status                    o_status
);

    cdir_pkg::t_state                        r_state, n_state;
    logic [cdir_pkg::LINE_INDEX_BITS-1:0]    r_clr_cnt;
    cdir_pkg::t_req                          r_req;
    logic [cdir_pkg::SHARER_W-1:0]           r_pend;
    logic                                    r_safe;
    logic [cdir_pkg::STATE_W-1:0]            r_grant;
    logic [cdir_pkg::STATE_W-1:0]            r_dstate;

    logic                                    in_acc;
    logic                                    pend_empty;
    cdir_pkg::t_entry                        cur;
    cdir_pkg::t_entry                        upd;
    logic [cdir_pkg::SHARER_W-1:0]           reqbit;
    logic [cdir_pkg::SHARER_W-1:0]           othermask;
    logic [cdir_pkg::SHARER_W-1:0]           set_old;
    logic [cdir_pkg::SHARER_W-1:0]           set_new;
    logic [cdir_pkg::SHARER_W-1:0]           victims;
    logic                                    safe;
    logic [cdir_pkg::STATE_W-1:0]            grant;
    logic [cdir_pkg::STATE_W-1:0]            dstate;

    assign pend_empty = (r_pend == '0);
    assign in_acc     = i_in_valid && !o_in_stall;

    // entry update
    always_comb begin
        cur       = cdir_pkg::t_entry'(i_ram_rdata);
        upd       = cur;
        reqbit    = (cdir_pkg::SHARER_W'(1) << r_req.requester) & cdir_pkg::HOLDER_MASK;
        othermask = ~(cdir_pkg::SHARER_W'(1) << r_req.requester);
        set_old   = cur.sharers & cdir_pkg::HOLDER_MASK;
        set_new   = set_old;
        victims   = '0;
        grant     = cdir_pkg::MODE_I;
        dstate    = cdir_pkg::MODE_I;

        if (!cur.owner_valid) begin
            upd.owner_valid = 1'b1;
            upd.owner_id    = r_req.requester;
            upd.read_only   = (r_req.mode != cdir_pkg::MODE_M);
        end else begin
            upd.shared_flag = (cur.owner_id != r_req.requester);
            if (r_req.mode == cdir_pkg::MODE_M) begin
                upd.read_only = 1'b0;
            end
        end
        safe = !upd.shared_flag || upd.read_only;

        case (r_req.mode)
            cdir_pkg::MODE_S: begin
                if (cdir_pkg::is_onehot(set_old) && (set_old != reqbit)) begin
                    victims = set_old;
                end
                dstate            = cdir_pkg::MODE_S;
                upd.modified_flag = 1'b0;
                set_new           = set_old | reqbit;
                grant = ((set_new == reqbit) && (reqbit != '0)) ? cdir_pkg::MODE_E
                                                                : cdir_pkg::MODE_S;
            end
            cdir_pkg::MODE_E, cdir_pkg::MODE_M: begin
                victims           = set_old & othermask;
                set_new           = reqbit;
                upd.modified_flag = (r_req.mode == cdir_pkg::MODE_M);
                grant             = r_req.mode;
            end
            default: begin
                if (cur.modified_flag) begin
                    upd.modified_flag = 1'b0;
                    set_new           = '0;
                end else begin
                    set_new = set_old & ~reqbit;
                end
                if (i_allow_reverse && (set_new == '0)) begin
                    upd.owner_valid = 1'b0;
                    upd.owner_id    = '0;
                    upd.shared_flag = 1'b0;
                    upd.read_only   = 1'b1;
                end
            end
        endcase
        upd.sharers = set_new & cdir_pkg::HOLDER_MASK;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cdir_pkg::ST_CLEAR: begin
                if (r_clr_cnt == {cdir_pkg::LINE_INDEX_BITS{1'b1}}) begin
                    n_state = cdir_pkg::ST_IDLE;
                end
            end
            cdir_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = cdir_pkg::ST_CALC;
                end
            end
            cdir_pkg::ST_CALC: begin
                n_state = cdir_pkg::ST_EMIT;
            end
            cdir_pkg::ST_EMIT: begin
                if (pend_empty && i_res_ready) begin
                    n_state = in_acc ? cdir_pkg::ST_CALC : cdir_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cdir_pkg::ST_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall  = 1'b1;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_req.line_index;
        o_ram_wdata = upd;
        o_res_valid = 1'b0;
        case (r_state)
            cdir_pkg::ST_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_clr_cnt;
                o_ram_wdata = cdir_pkg::ENTRY_RESET;
            end
            cdir_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            cdir_pkg::ST_CALC: begin
                o_ram_we = 1'b1;
            end
            cdir_pkg::ST_EMIT: begin
                o_res_valid = 1'b1;
                o_in_stall  = !(pend_empty && i_res_ready);
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase

        o_ram_re    = in_acc;
        o_ram_raddr = i_in.line_index;

        o_res.kind      = pend_empty ? cdir_pkg::KIND_GRANT : cdir_pkg::KIND_DOWNGRADE;
        o_res.target    = pend_empty ? r_req.requester : cdir_pkg::lowest_id(r_pend);
        o_res.new_state = pend_empty ? r_grant : r_dstate;
        o_res.safe      = r_safe;
        o_res.line_out  = r_req.line_index;
        o_res.last      = pend_empty;

        o_status.clearing = (r_state == cdir_pkg::ST_CLEAR);
        o_status.pending  = (r_state == cdir_pkg::ST_EMIT) && !pend_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cdir_pkg::ST_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == cdir_pkg::ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + cdir_pkg::LINE_INDEX_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= i_in;
        end
        if (r_state == cdir_pkg::ST_CALC) begin
            r_pend   <= victims;
            r_safe   <= safe;
            r_grant  <= grant;
            r_dstate <= dstate;
        end else if ((r_state == cdir_pkg::ST_EMIT) && !pend_empty && i_res_ready) begin
            r_pend <= r_pend & (r_pend - cdir_pkg::SHARER_W'(1));
        end
    end

endmodule

// ===== test/coherence_directory_with_safety_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coherence_directory_with_safety_test
// Self-checking bench for the coherence directory. Requests are driven through
// the input handshake, a behavioral directory model predicts the downgrade and
// grant transactions of each accepted request, and every result transaction
// is compared field by field, in order. Directed sequences cover first touch,
// sharing, repeated sharing, invalidation of many holders, modified
// writebacks, writebacks by non-holders and the reverse transition; random
// traffic on a few hot lines follows, first with random idle and stall bursts, then without.
// ----------------------------------------------------------------------------
module coherence_directory_with_safety_test;

    localparam int NUM_LINES   = 1 << cdir_pkg::LINE_INDEX_BITS;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 16;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    cdir_pkg::t_req   in_data;
    logic             out_valid;
    logic             out_stall;
    cdir_pkg::t_rsp   out_data;
    logic             cfg_wr_en;
    logic             cfg_wr_data;

    coherence_directory_with_safety uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in          (in_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out         (out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // directory model
    cdir_pkg::t_entry dir_model [0:NUM_LINES-1];
    bit               reverse_en;
    cdir_pkg::t_rsp   expected_rsp [$];

    int     error_count;
    int     cycle_count;
    bit     idle_on;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    function automatic cdir_pkg::t_rsp make_rsp(
        input logic                                 kind,
        input logic [cdir_pkg::CACHE_ID_W-1:0]      tgt,
        input logic [cdir_pkg::STATE_W-1:0]         st,
        input logic                                 safe,
        input logic [cdir_pkg::LINE_INDEX_BITS-1:0] ln,
        input logic                                 last
    );
        cdir_pkg::t_rsp r;
        r.kind      = kind;
        r.target    = tgt;
        r.new_state = st;
        r.safe      = safe;
        r.line_out  = ln;
        r.last      = last;
        return r;
    endfunction

    function automatic void queue_rsp(input cdir_pkg::t_rsp r);
        expected_rsp = {expected_rsp, r};
    endfunction

    function automatic void predict_request(input cdir_pkg::t_req r);
        cdir_pkg::t_entry                e;
        logic [cdir_pkg::SHARER_W-1:0]   holders;
        logic [cdir_pkg::SHARER_W-1:0]   req_bit;
        logic [cdir_pkg::STATE_W-1:0]    grant;
        logic                            safe;

        e       = dir_model[r.line_index];
        holders = e.sharers & cdir_pkg::HOLDER_MASK;
        req_bit = (cdir_pkg::SHARER_W'(1) << r.requester) & cdir_pkg::HOLDER_MASK;

        if (!e.owner_valid) begin
            e.owner_valid = 1'b1;
            e.owner_id    = r.requester;
            e.read_only   = (r.mode != cdir_pkg::MODE_M);
        end else begin
            e.shared_flag = (e.owner_id != r.requester);
            if (r.mode == cdir_pkg::MODE_M) begin
                e.read_only = 1'b0;
            end
        end
        safe = !e.shared_flag || e.read_only;

        if (r.mode == cdir_pkg::MODE_S) begin
            if ($countones(holders) == 1 && holders != req_bit) begin
                for (int i = 0; i < cdir_pkg::SHARER_W; i++) begin
                    if (holders[i]) begin
                        queue_rsp(make_rsp(cdir_pkg::KIND_DOWNGRADE,
                                           cdir_pkg::CACHE_ID_W'(i), cdir_pkg::MODE_S,
                                           safe, r.line_index, 1'b0));
                    end
                end
            end
            e.modified_flag = 1'b0;
            holders = holders | req_bit;
            grant = ($countones(holders) == 1 && holders == req_bit) ? cdir_pkg::MODE_E
                                                                     : cdir_pkg::MODE_S;
        end else if (r.mode == cdir_pkg::MODE_E || r.mode == cdir_pkg::MODE_M) begin
            for (int i = 0; i < cdir_pkg::SHARER_W; i++) begin
                if (holders[i] && i != r.requester) begin
                    queue_rsp(make_rsp(cdir_pkg::KIND_DOWNGRADE,
                                       cdir_pkg::CACHE_ID_W'(i), cdir_pkg::MODE_I,
                                       safe, r.line_index, 1'b0));
                end
            end
            holders = req_bit;
            e.modified_flag = (r.mode == cdir_pkg::MODE_M);
            grant = r.mode;
        end else begin
            if (e.modified_flag) begin
                e.modified_flag = 1'b0;
                holders = '0;
            end else begin
                holders = holders & ~req_bit;
            end
            if (reverse_en && holders == '0) begin
                e.owner_valid = 1'b0;
                e.owner_id    = '0;
                e.shared_flag = 1'b0;
                e.read_only   = 1'b1;
            end
            grant = cdir_pkg::MODE_I;
        end

        e.sharers = holders & cdir_pkg::HOLDER_MASK;
        dir_model[r.line_index] = e;
        queue_rsp(make_rsp(cdir_pkg::KIND_GRANT, r.requester, grant, safe,
                           r.line_index, 1'b1));
    endfunction

    // result checker
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_rsp.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction %p", out_data));
            end else begin
                cdir_pkg::t_rsp want;
                want = expected_rsp.pop_front();
                check_field("kind", 16'(out_data.kind), 16'(want.kind));
                check_field("target", 16'(out_data.target), 16'(want.target));
                check_field("new_state", 16'(out_data.new_state), 16'(want.new_state));
                check_field("safe", 16'(out_data.safe), 16'(want.safe));
                check_field("line_out", 16'(out_data.line_out), 16'(want.line_out));
                check_field("last", 16'(out_data.last), 16'(want.last));
            end
        end
    end

    // result side stall bursts
    initial begin : out_stall_gen
        int n;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            n = $urandom_range(1, 7);
            out_stall <= (idle_on && $urandom_range(0, 2) == 0);
            repeat (n - 1) @(negedge clk);
        end
    end

    function automatic cdir_pkg::t_req make_req(input logic [cdir_pkg::STATE_W-1:0] mode,
                                                input int requester, input int ln);
        cdir_pkg::t_req r;
        r.mode       = mode;
        r.requester  = cdir_pkg::CACHE_ID_W'(requester);
        r.line_index = cdir_pkg::LINE_INDEX_BITS'(ln);
        return r;
    endfunction

    // called and returns at a falling edge
    task automatic send_request(input cdir_pkg::t_req r);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do begin
            @(posedge clk);
        end while (in_stall);
        predict_request(r);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_rsp.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reverse(input bit value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        reverse_en = value;
    endtask

    task automatic test_directed_basics();
        write_reverse(1'b0);
        // first touch, repeat, second sharer, third sharer
        send_request(make_req(cdir_pkg::MODE_S, 0, 0));
        send_request(make_req(cdir_pkg::MODE_S, 0, 0));
        send_request(make_req(cdir_pkg::MODE_S, 7, 0));
        send_request(make_req(cdir_pkg::MODE_S, 3, 0));
        send_request(make_req(cdir_pkg::MODE_S, 3, 0));
        // invalidate all other holders
        send_request(make_req(cdir_pkg::MODE_E, 7, 0));
        send_request(make_req(cdir_pkg::MODE_M, 2, 0));
        // writeback of modified line by non-holder empties it
        send_request(make_req(cdir_pkg::MODE_I, 5, 0));
        send_request(make_req(cdir_pkg::MODE_I, 4, 0));
        // first touch for write, then reader: not safe
        send_request(make_req(cdir_pkg::MODE_M, 7, NUM_LINES - 1));
        send_request(make_req(cdir_pkg::MODE_S, 0, NUM_LINES - 1));
        send_request(make_req(cdir_pkg::MODE_I, 0, NUM_LINES - 1));
        send_request(make_req(cdir_pkg::MODE_I, 6, NUM_LINES - 1));
        send_request(make_req(cdir_pkg::MODE_E, 6, NUM_LINES - 1));
        // upgrade by the sole holder
        send_request(make_req(cdir_pkg::MODE_E, 5, 'h2AA));
        send_request(make_req(cdir_pkg::MODE_M, 5, 'h2AA));
        send_request(make_req(cdir_pkg::MODE_I, 5, 'h2AA));
        send_request(make_req(cdir_pkg::MODE_S, 1, 'h2AA));
        wait_idle();
    endtask

    task automatic test_reverse_transition();
        write_reverse(1'b1);
        for (int i = 0; i < cdir_pkg::NUM_CACHES; i++) begin
            send_request(make_req(cdir_pkg::MODE_S, i, 'h155));
        end
        // seven downgrades ahead of the grant
        send_request(make_req(cdir_pkg::MODE_M, 3, 'h155));
        send_request(make_req(cdir_pkg::MODE_I, 3, 'h155));
        send_request(make_req(cdir_pkg::MODE_S, 5, 'h155));
        // last holder leaves a clean line
        send_request(make_req(cdir_pkg::MODE_S, 2, 'h0F0));
        send_request(make_req(cdir_pkg::MODE_I, 2, 'h0F0));
        send_request(make_req(cdir_pkg::MODE_M, 4, 'h0F0));
        wait_idle();
        write_reverse(1'b0);
    endtask

    function automatic cdir_pkg::t_req random_request(input int hot_lines [6]);
        cdir_pkg::t_req r;
        int             w;
        w = $urandom_range(0, 9);
        if (w < 4) begin
            r.mode = cdir_pkg::MODE_S;
        end else if (w < 6) begin
            r.mode = cdir_pkg::MODE_E;
        end else if (w < 8) begin
            r.mode = cdir_pkg::MODE_M;
        end else begin
            r.mode = cdir_pkg::MODE_I;
        end
        r.requester = cdir_pkg::CACHE_ID_W'($urandom_range(0, 7));
        if ($urandom_range(0, 9) < 8) begin
            r.line_index = cdir_pkg::LINE_INDEX_BITS'(hot_lines[$urandom_range(0, 5)]);
        end else begin
            r.line_index = cdir_pkg::LINE_INDEX_BITS'($urandom_range(0, NUM_LINES - 1));
        end
        return r;
    endfunction

    task automatic test_random_traffic();
        int hot_lines [6];
        for (int phase = 0; phase < 4; phase++) begin
            write_reverse(phase[0]);
            foreach (hot_lines[i]) begin
                hot_lines[i] = $urandom_range(0, NUM_LINES - 1);
            end
            for (int n = 0; n < 65; n++) begin
                send_request(random_request(hot_lines));
            end
            wait_idle();
        end
    endtask

    task automatic test_back_to_back();
        int hot_lines [6];
        idle_on = 1'b0;
        write_reverse(1'b1);
        foreach (hot_lines[i]) begin
            hot_lines[i] = $urandom_range(0, NUM_LINES - 1);
        end
        for (int n = 0; n < 60; n++) begin
            send_request(random_request(hot_lines));
        end
        wait_idle();
    endtask

    initial begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        idle_on     = 1'b1;
        reverse_en  = 1'b0;
        error_count = 0;
        cycle_count = 0;
        for (int i = 0; i < NUM_LINES; i++) begin
            dir_model[i] = cdir_pkg::ENTRY_RESET;
        end
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_basics();
        test_reverse_transition();
        test_random_traffic();
        test_back_to_back();

        if (expected_rsp.size() != 0) begin
            report_mismatch($sformatf("%0d transactions never arrived", expected_rsp.size()));
        end
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
